// File: design/gwpk_pkg.sv
// Shared types and constants for the genotype window polynomial kernel.
// Used by gwpk_ctrl, gwpk_datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gwpk_pkg;

    // Field widths fixed by the item format
    localparam int ALLELE_W  = 8;
    localparam int DEGREE_W  = 4;
    localparam int WINDOW_W  = 5;
    localparam int TOTAL_W   = 64;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 5;

    // Allele byte that marks a missing call ('0')
    localparam logic [ALLELE_W-1:0] MISSING_ALLELE = 8'h30;

    // Reset values of the configuration registers
    localparam logic [DEGREE_W-1:0] DEGREE_RST = 4'd1;
    localparam logic [WINDOW_W-1:0] WINDOW_RST = 5'd1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEGREE      = 2'd0,
        REG_WINDOW_LOCI = 2'd1,
        REG_ADD_ONE     = 2'd2
    } gwpk_reg_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;       // capture an input beat, score it, shift history
        logic start_main;   // load power unit with the full window sum
        logic start_flush;  // load power unit with the truncated window sum
        logic pow_step;     // one multiply of the power loop
        logic add_win;      // add finished power into the running total
        logic load_m;       // load count of truncated windows to flush
        logic dec_m;        // one truncated window done
        logic emit;         // move total into the output register, clear string
    } gwpk_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic win_due;      // a full window completes on this locus
        logic last;         // captured locus ends the string
        logic m_zero;       // no truncated windows left
        logic pow_done;     // power loop has no multiplies left
        logic out_free;     // output register can take a new result
    } gwpk_sts_t;

endpackage

`default_nettype wire

// File: design/gwpk_ctrl.sv
// Controller state machine for the genotype window polynomial kernel.
// Depends on gwpk_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module gwpk_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire gwpk_pkg::gwpk_sts_t   sts,
    output gwpk_pkg::gwpk_cmd_t        cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAIN,
        ST_POW,
        ST_ADD,
        ST_FLUSH,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   flushing_reg, flushing_next;
    logic   ready_reg, ready_next;

    assign in_ready = ready_reg;

    // Next state and command decode
    always_comb
    begin
        state_next    = state_reg;
        flushing_next = flushing_reg;
        cmd           = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && ready_reg)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_MAIN;
                end
            end
            ST_MAIN:
            begin
                if (sts.win_due)
                begin
                    cmd.start_main = 1'b1;
                    state_next     = ST_POW;
                end
                else if (sts.last)
                begin
                    cmd.load_m = 1'b1;
                    state_next = ST_FLUSH;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_POW:
            begin
                if (sts.pow_done)
                begin
                    state_next = ST_ADD;
                end
                else
                begin
                    cmd.pow_step = 1'b1;
                end
            end
            ST_ADD:
            begin
                cmd.add_win = 1'b1;
                if (flushing_reg)
                begin
                    cmd.dec_m  = 1'b1;
                    state_next = ST_FLUSH;
                end
                else if (sts.last)
                begin
                    cmd.load_m = 1'b1;
                    state_next = ST_FLUSH;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                if (sts.m_zero)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.start_flush = 1'b1;
                    flushing_next   = 1'b1;
                    state_next      = ST_POW;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    flushing_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        ready_next = (state_next == ST_IDLE);
    end

    // State and registered ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            flushing_reg <= 1'b0;
            ready_reg    <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            flushing_reg <= flushing_next;
            ready_reg    <= ready_next;
        end
    end

endmodule

`default_nettype wire

// File: design/gwpk_datapath.sv
// Datapath: config registers, locus scoring, score history, window sum,
// shared power multiplier, saturating total and output register.
// Depends on gwpk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gwpk_datapath #(
    parameter int MAX_WINDOW = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration
    input  wire logic                              cfg_we,
    input  wire logic [gwpk_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [gwpk_pkg::CFG_DAT_W-1:0]    cfg_data,
    // input item fields
    input  wire logic [gwpk_pkg::ALLELE_W-1:0]     allele_a1,
    input  wire logic [gwpk_pkg::ALLELE_W-1:0]     allele_a2,
    input  wire logic [gwpk_pkg::ALLELE_W-1:0]     allele_b1,
    input  wire logic [gwpk_pkg::ALLELE_W-1:0]     allele_b2,
    input  wire logic [gwpk_pkg::ALLELE_W-1:0]     minor_allele,
    input  wire logic [gwpk_pkg::ALLELE_W-1:0]     major_allele,
    input  wire logic                              last_locus,
    // control
    input  wire gwpk_pkg::gwpk_cmd_t               cmd,
    output gwpk_pkg::gwpk_sts_t                    sts,
    // result
    input  wire logic                              out_ready,
    output logic                                   out_valid,
    output logic [gwpk_pkg::TOTAL_W-1:0]           kernel_total,
    output logic                                   total_saturated,
    output logic                                   impossible_seen
);

    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int BW = CW + 1;
    localparam int PW = gwpk_pkg::TOTAL_W + BW;
    localparam int LW = (CW > gwpk_pkg::WINDOW_W) ? CW : gwpk_pkg::WINDOW_W;
    localparam int TW = gwpk_pkg::TOTAL_W;

    // Configuration registers
    logic [gwpk_pkg::DEGREE_W-1:0] degree_reg;
    logic [gwpk_pkg::WINDOW_W-1:0] window_reg;
    logic                          add_one_reg;

    // Per-string state
    logic [MAX_WINDOW-1:0] hist_reg;        // bit 0 newest
    logic [CW-1:0]         seen_reg;
    logic [TW-1:0]         total_reg;
    logic                  ovf_reg;
    logic                  imp_reg;
    logic                  last_reg;
    logic [CW-1:0]         m_reg;

    // Power unit
    logic [BW-1:0]               base_reg;
    logic [TW-1:0]               acc_reg;
    logic [gwpk_pkg::DEGREE_W-1:0] cnt_reg;

    // Output register
    logic          out_valid_reg;
    logic [TW-1:0] out_total_reg;
    logic          out_sat_reg;
    logic          out_imp_reg;

    logic [LW-1:0]         wl_ext;
    logic [CW-1:0]         w_eff;
    logic                  a_open, b_open, sc, imp_hit;
    logic [CW-1:0]         sum_len;
    logic [MAX_WINDOW-1:0] win_mask;
    logic [CW-1:0]         win_sum;
    logic [BW-1:0]         base_next;
    logic [PW-1:0]         prod;
    logic [TW:0]           add_sum;
    logic [CW-1:0]         m_load;

    // Effective window length, clamped to the history depth
    always_comb
    begin
        wl_ext = LW'(window_reg);
        if (wl_ext > LW'(MAX_WINDOW))
            w_eff = CW'(MAX_WINDOW);
        else
            w_eff = CW'(wl_ext);
    end

    // Locus score
    always_comb
    begin
        a_open = (allele_a1 != allele_a2) || (allele_a1 == gwpk_pkg::MISSING_ALLELE)
              || (allele_a2 == gwpk_pkg::MISSING_ALLELE);
        b_open = (allele_b1 != allele_b2) || (allele_b1 == gwpk_pkg::MISSING_ALLELE)
              || (allele_b2 == gwpk_pkg::MISSING_ALLELE);
        sc      = 1'b0;
        imp_hit = 1'b0;
        if (a_open && b_open)
        begin
            sc = 1'b1;
        end
        else if ((allele_a1 == allele_a2) && (allele_b1 == allele_b2)
              && (allele_a1 == allele_b1))
        begin
            if ((allele_a1 == minor_allele) || (allele_a1 == major_allele))
                sc = 1'b1;
            else
                imp_hit = 1'b1;
        end
    end

    // Sum of the newest sum_len scores
    always_comb
    begin
        sum_len = cmd.start_flush ? m_reg : w_eff;
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            win_mask[i] = (CW'(i) < sum_len);
        end
        win_sum   = CW'($countones(hist_reg & win_mask));
        base_next = BW'(win_sum) + BW'(add_one_reg);
    end

    // Multiply and add paths
    always_comb
    begin
        prod    = PW'(acc_reg) * PW'(base_reg);
        add_sum = {1'b0, total_reg} + {1'b0, acc_reg};
        if (seen_reg >= w_eff)
            m_load = w_eff - CW'(1);
        else
            m_load = seen_reg;
        if (w_eff == '0)
            m_load = '0;
    end

    // Status to controller
    always_comb
    begin
        sts.win_due  = (w_eff == '0) || (seen_reg >= w_eff);
        sts.last     = last_reg;
        sts.m_zero   = (m_reg == '0);
        sts.pow_done = (cnt_reg == '0);
        sts.out_free = !out_valid_reg || out_ready;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg  <= gwpk_pkg::DEGREE_RST;
            window_reg  <= gwpk_pkg::WINDOW_RST;
            add_one_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gwpk_pkg::REG_DEGREE:      degree_reg  <= cfg_data[gwpk_pkg::DEGREE_W-1:0];
                gwpk_pkg::REG_WINDOW_LOCI: window_reg  <= cfg_data;
                gwpk_pkg::REG_ADD_ONE:     add_one_reg <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    // String state: history, counts, total and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg  <= '0;
            seen_reg  <= '0;
            total_reg <= '0;
            ovf_reg   <= 1'b0;
            imp_reg   <= 1'b0;
            last_reg  <= 1'b0;
            m_reg     <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                last_reg <= last_locus;
                if (w_eff != '0)
                begin
                    hist_reg <= MAX_WINDOW'({hist_reg, sc});
                    if (seen_reg < CW'(MAX_WINDOW))
                        seen_reg <= seen_reg + CW'(1);
                    if (imp_hit)
                        imp_reg <= 1'b1;
                end
            end
            if (cmd.pow_step && (prod[PW-1:TW] != '0))
                ovf_reg <= 1'b1;
            if (cmd.add_win)
            begin
                if (add_sum[TW])
                begin
                    total_reg <= '1;
                    ovf_reg   <= 1'b1;
                end
                else
                begin
                    total_reg <= add_sum[TW-1:0];
                end
            end
            if (cmd.load_m)
                m_reg <= m_load;
            else if (cmd.dec_m)
                m_reg <= m_reg - CW'(1);
            if (cmd.emit)
            begin
                hist_reg  <= '0;
                seen_reg  <= '0;
                total_reg <= '0;
                ovf_reg   <= 1'b0;
                imp_reg   <= 1'b0;
                last_reg  <= 1'b0;
            end
        end
    end

    // Power loop: acc = base^degree, one multiply per cycle, clamps on overflow
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.start_main || cmd.start_flush)
        begin
            cnt_reg <= degree_reg;
        end
        else if (cmd.pow_step)
        begin
            if (prod[PW-1:TW] != '0)
                cnt_reg <= '0;
            else
                cnt_reg <= cnt_reg - gwpk_pkg::DEGREE_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_main || cmd.start_flush)
        begin
            base_reg <= base_next;
            acc_reg  <= TW'(1);
        end
        else if (cmd.pow_step)
        begin
            if (prod[PW-1:TW] != '0)
                acc_reg <= '1;
            else
                acc_reg <= prod[TW-1:0];
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_total_reg <= total_reg;
            out_sat_reg   <= ovf_reg;
            out_imp_reg   <= imp_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign kernel_total    = out_total_reg;
    assign total_saturated = out_sat_reg;
    assign impossible_seen = out_imp_reg;

endmodule

`default_nettype wire

// File: design/genotype_window_poly_kernel.sv
// Top level of the genotype window polynomial kernel (SNP string kernel).
// Instantiates gwpk_ctrl and gwpk_datapath; depends on gwpk_pkg.
//
//   channel   | dir | handshake              | payload
//   ----------+-----+------------------------+------------------------------------
//   s_axis    | in  | s_axis_tvalid/tready   | tdata: 6 allele bytes, tlast: last locus
//   m_axis    | out | m_axis_tvalid/tready   | tdata: kernel total, tuser: flags
//   cfg       | in  | cfg_we                 | cfg_index, cfg_data (no read-back)
//
// Each locus beat is scored, and any window that it completes is raised to the degree
// and added to the total; the shared 64-bit by narrow multiplier runs one multiply a cycle.
// A last-locus beat also flushes up to min(window_loci, MAX_WINDOW) - 1 truncated
// windows, then loads the output register once it is free.
// The result register lets the next string start while a total waits.
// Reset clears all string state and sets degree = 1, window_loci = 1, add_one = 0.
`timescale 1ns / 1ps
`default_nettype none

module genotype_window_poly_kernel #(
    parameter int MAX_WINDOW = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // locus stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // allele_a1, allele_a2, allele_b1,
                                             // allele_b2, minor_allele, major_allele
    input  wire logic        s_axis_tlast,   // last_locus
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // kernel_total
    output logic [1:0]       m_axis_tuser,   // total_saturated, impossible_seen
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [gwpk_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [gwpk_pkg::CFG_DAT_W-1:0] cfg_data
);

    gwpk_pkg::gwpk_cmd_t cmd;
    gwpk_pkg::gwpk_sts_t sts;
    logic                total_saturated;
    logic                impossible_seen;

    gwpk_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gwpk_datapath #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .allele_a1       (s_axis_tdata[7:0]),
        .allele_a2       (s_axis_tdata[15:8]),
        .allele_b1       (s_axis_tdata[23:16]),
        .allele_b2       (s_axis_tdata[31:24]),
        .minor_allele    (s_axis_tdata[39:32]),
        .major_allele    (s_axis_tdata[47:40]),
        .last_locus      (s_axis_tlast),
        .cmd             (cmd),
        .sts             (sts),
        .out_ready       (m_axis_tready),
        .out_valid       (m_axis_tvalid),
        .kernel_total    (m_axis_tdata),
        .total_saturated (total_saturated),
        .impossible_seen (impossible_seen)
    );

    assign m_axis_tuser = {impossible_seen, total_saturated};

endmodule

`default_nettype wire

// File: design/gwpk_checker.sv
// Port-level checker for genotype_window_poly_kernel, bound to the top level.
// Watches only the stream handshakes and the result payload; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module gwpk_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);

    // A stalled result beat holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // One locus at a time: ready drops after every accepted beat
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second locus taken while one is in work");

    // A new result is loaded only as the engine returns to idle
    a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result appeared while engine busy");

    // A saturated total is clamped to all ones
    a_sat_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata == 64'hFFFF_FFFF_FFFF_FFFF))
        else $error("saturation flag without clamped total");

endmodule

bind genotype_window_poly_kernel gwpk_checker u_gwpk_checker (.*);

`default_nettype wire

// File: tb/sv/tb_genotype_window_poly_kernel.sv
// Self-checking testbench for genotype_window_poly_kernel: directed and random
// loci, a scoreboard that predicts each string's kernel total, and stream checks.
// Depends on gwpk_pkg and the genotype_window_poly_kernel RTL.
`timescale 1ns / 1ps

localparam int WINDOW_DEPTH = 16;
localparam logic [63:0] TOTAL_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

typedef struct {
    logic [7:0] allele_a1;
    logic [7:0] allele_a2;
    logic [7:0] allele_b1;
    logic [7:0] allele_b2;
    logic [7:0] minor_allele;
    logic [7:0] major_allele;
    logic       last_locus;
} locus_t;

typedef struct {
    logic [63:0] kernel_total;
    logic        total_saturated;
    logic        impossible_seen;
} kernel_result_t;

// Predicts the kernel total of each string and checks the emitted beats
class snp_kernel_scoreboard;
    logic [3:0]              degree;
    logic [4:0]              window_loci;
    logic                    add_one;
    logic [WINDOW_DEPTH-1:0] score_bits;     // bit k = score of k-th newest locus
    int unsigned             loci_seen;
    logic [63:0]             total;
    logic                    overflow_mark;
    logic                    impossible_mark;
    kernel_result_t          totals_due[$];
    int unsigned             mismatches;
    int unsigned             totals_checked;
    int unsigned             saturated_count;
    int unsigned             impossible_count;

    function new();
        degree = gwpk_pkg::DEGREE_RST;
        window_loci = gwpk_pkg::WINDOW_RST;
        add_one = 1'b0;
        mismatches = 0;
        totals_checked = 0;
        saturated_count = 0;
        impossible_count = 0;
        clear_string();
    endfunction

    function void clear_string();
        score_bits = '0;
        loci_seen = 0;
        total = '0;
        overflow_mark = 1'b0;
        impossible_mark = 1'b0;
    endfunction

    function void note_register(gwpk_pkg::gwpk_reg_t idx, logic [4:0] value);
        case (idx)
            gwpk_pkg::REG_DEGREE:      degree = value[3:0];
            gwpk_pkg::REG_WINDOW_LOCI: window_loci = value;
            gwpk_pkg::REG_ADD_ONE:     add_one = value[0];
            default: ;
        endcase
    endfunction

    // base^degree, clamped on overflow
    function logic [63:0] window_power(logic [63:0] base);
        logic [63:0] acc;
        acc = 64'd1;
        for (int k = 0; k < int'(degree); k++)
        begin
            if (base != 0 && acc > TOTAL_MAX / base)
            begin
                overflow_mark = 1'b1;
                return TOTAL_MAX;
            end
            acc = acc * base;
        end
        return acc;
    endfunction

    function void add_window_power(int unsigned score);
        logic [63:0] p;
        p = window_power(64'(score) + 64'(add_one));
        if (total > TOTAL_MAX - p)
        begin
            total = TOTAL_MAX;
            overflow_mark = 1'b1;
        end
        else
            total = total + p;
    endfunction

    function int unsigned recent_score_sum(int unsigned count);
        int unsigned s;
        s = 0;
        for (int unsigned k = 0; k < count && k < WINDOW_DEPTH; k++)
            s += score_bits[k];
        return s;
    endfunction

    function void note_locus(locus_t l);
        int unsigned    w;
        int unsigned    m;
        logic           a_open;
        logic           b_open;
        logic           sc;
        kernel_result_t r;
        w = (window_loci > WINDOW_DEPTH) ? WINDOW_DEPTH : window_loci;
        if (w == 0)
            add_window_power(0);
        else
        begin
            // score the locus: both open, or a known homozygous match
            sc = 1'b0;
            a_open = l.allele_a1 != l.allele_a2 || l.allele_a1 == gwpk_pkg::MISSING_ALLELE
                     || l.allele_a2 == gwpk_pkg::MISSING_ALLELE;
            b_open = l.allele_b1 != l.allele_b2 || l.allele_b1 == gwpk_pkg::MISSING_ALLELE
                     || l.allele_b2 == gwpk_pkg::MISSING_ALLELE;
            if (a_open && b_open)
                sc = 1'b1;
            else if (l.allele_a1 == l.allele_a2 && l.allele_b1 == l.allele_b2
                     && l.allele_a1 == l.allele_b1)
            begin
                if (l.allele_a1 == l.minor_allele || l.allele_a1 == l.major_allele)
                    sc = 1'b1;
                else
                    impossible_mark = 1'b1;
            end
            score_bits = {score_bits[WINDOW_DEPTH-2:0], sc};
            if (loci_seen < WINDOW_DEPTH)
                loci_seen++;
            if (loci_seen >= w)
                add_window_power(recent_score_sum(w));
        end
        if (!l.last_locus)
            return;
        // flush the truncated windows at the string end
        if (w != 0)
        begin
            m = (loci_seen >= w) ? w - 1 : loci_seen;
            while (m > 0)
            begin
                add_window_power(recent_score_sum(m));
                m--;
            end
        end
        r.kernel_total = total;
        r.total_saturated = overflow_mark;
        r.impossible_seen = impossible_mark;
        totals_due.push_back(r);
        clear_string();
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("[%0t] ERROR %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    task check_result(logic [63:0] kernel_total, logic [1:0] flags);
        kernel_result_t want;
        if (totals_due.size() == 0)
        begin
            report_mismatch("result beat with nothing expected", kernel_total, 64'd0);
            return;
        end
        want = totals_due.pop_front();
        totals_checked++;
        if (want.total_saturated)
            saturated_count++;
        if (want.impossible_seen)
            impossible_count++;
        if (kernel_total !== want.kernel_total)
            report_mismatch("kernel_total", kernel_total, want.kernel_total);
        if (flags[0] !== want.total_saturated)
            report_mismatch("total_saturated", 64'(flags[0]), 64'(want.total_saturated));
        if (flags[1] !== want.impossible_seen)
            report_mismatch("impossible_seen", 64'(flags[1]), 64'(want.impossible_seen));
    endtask
endclass

module tb_genotype_window_poly_kernel;

    localparam int RANDOM_LOCI   = 800;
    localparam int SETTLE_CYCLES = 320;     // longest flush at degree 15, window 16
    localparam int WATCHDOG_MAX  = 4000;

    localparam logic [7:0] SYM_A = 8'h41;
    localparam logic [7:0] SYM_C = 8'h43;
    localparam logic [7:0] SYM_G = 8'h47;
    localparam logic [7:0] SYM_T = 8'h54;
    localparam logic [7:0] SYM_MISSING = gwpk_pkg::MISSING_ALLELE;

    // register settings walked first in the random part
    localparam logic [3:0] FIX_DEG [8] = '{4'd0, 4'd15, 4'd8, 4'd2, 4'd0, 4'd1, 4'd3, 4'd15};
    localparam logic [4:0] FIX_WIN [8] = '{5'd0, 5'd16, 5'd16, 5'd31, 5'd5, 5'd1, 5'd17, 5'd31};
    localparam logic       FIX_ADD [8] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

    typedef enum int { CONTENT_MIXED, CONTENT_DENSE, CONTENT_NOISE } content_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // allele_a1, allele_a2, allele_b1, allele_b2, minor, major
    logic        s_axis_tlast;   // last_locus
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;   // kernel_total
    logic [1:0]  m_axis_tuser;   // total_saturated, impossible_seen
    logic        cfg_we;
    logic [gwpk_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [gwpk_pkg::CFG_DAT_W-1:0] cfg_data;

    snp_kernel_scoreboard sb = new();
    bit          no_idle = 1'b0;
    int unsigned loci_sent = 0;
    int unsigned settings_used = 0;
    int unsigned result_stall = 0;
    int unsigned quiet_cycles = 0;

    genotype_window_poly_kernel dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_symbol();
        case ($urandom_range(0, 5))
            0: return SYM_A;
            1: return SYM_C;
            2: return SYM_G;
            3: return SYM_T;
            4: return SYM_MISSING;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic locus_t mk_locus(logic [7:0] a1, logic [7:0] a2, logic [7:0] b1,
                                        logic [7:0] b2, logic [7:0] mn, logic [7:0] mj,
                                        logic last);
        locus_t l;
        l.allele_a1 = a1;
        l.allele_a2 = a2;
        l.allele_b1 = b1;
        l.allele_b2 = b2;
        l.minor_allele = mn;
        l.major_allele = mj;
        l.last_locus = last;
        return l;
    endfunction

    function automatic locus_t rand_locus(content_t mode, logic last);
        locus_t     l;
        logic [7:0] x;
        int unsigned kind;
        l = mk_locus(pick_symbol(), pick_symbol(), pick_symbol(), pick_symbol(),
                     pick_symbol(), pick_symbol(), last);
        if (mode == CONTENT_NOISE)
            return mk_locus(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                            8'($urandom), 8'($urandom), last);
        kind = (mode == CONTENT_DENSE) ? $urandom_range(0, 2) : $urandom_range(0, 7);
        x = pick_symbol();
        case (kind)
            0:  // both heterozygous
            begin
                l.allele_a2 = l.allele_a1 + 8'($urandom_range(1, 255));
                l.allele_b2 = l.allele_b1 + 8'($urandom_range(1, 255));
            end
            1:  // same homozygous allele, known at this position
            begin
                l = mk_locus(x, x, x, x, l.minor_allele, l.major_allele, last);
                if ($urandom_range(0, 1) == 0)
                    l.minor_allele = x;
                else
                    l.major_allele = x;
            end
            2:  // missing calls on both sides
            begin
                l.allele_a2 = SYM_MISSING;
                l.allele_b1 = SYM_MISSING;
            end
            3:  // homozygous match on an unknown allele
                l = mk_locus(x, x, x, x, x + 8'($urandom_range(1, 255)),
                             x + 8'($urandom_range(1, 255)), last);
            4:  // homozygous on different alleles
            begin
                l.allele_a1 = x;
                l.allele_a2 = x;
                l.allele_b1 = x + 8'($urandom_range(1, 255));
                l.allele_b2 = l.allele_b1;
            end
            5:  // one side homozygous
                l.allele_b2 = l.allele_b1;
            default: ;
        endcase
        return l;
    endfunction

    // one locus beat: optional gap, then hold until accepted
    task automatic send_locus(locus_t l);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {l.major_allele, l.minor_allele, l.allele_b2, l.allele_b1,
                         l.allele_a2, l.allele_a1};
        s_axis_tlast <= l.last_locus;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_locus(l);
        loci_sent++;
    endtask

    task automatic write_reg(gwpk_pkg::gwpk_reg_t idx, logic [4:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        sb.note_register(idx, value);
    endtask

    // drain every pending total, let the block settle, then reprogram it
    task automatic change_setting(logic [3:0] deg, logic [4:0] win, logic add);
        s_axis_tvalid <= 1'b0;
        while (sb.totals_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(gwpk_pkg::REG_DEGREE, 5'(deg));
        write_reg(gwpk_pkg::REG_WINDOW_LOCI, win);
        write_reg(gwpk_pkg::REG_ADD_ONE, 5'(add));
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic send_string(content_t mode, int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            send_locus(rand_locus(mode, i == len - 1));
    endtask

    // result side: random stalls, check every accepted beat
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
        if (result_stall > 0)
        begin
            m_axis_tready <= 1'b0;
            result_stall <= result_stall - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            result_stall <= pick_gap();
        end
    end

    // watchdog on cycles with no beat on either stream
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_MAX)
        begin
            $display("watchdog expired after %0d quiet cycles", quiet_cycles);
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int unsigned random_loci;
        int unsigned phase;
        int unsigned n_strings;
        int unsigned len;
        int unsigned r;
        content_t    mode;

        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tlast <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= gwpk_pkg::REG_DEGREE;
        cfg_data <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: field extremes and each scoring case
        send_locus(mk_locus(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        send_locus(mk_locus(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 1'b0));
        send_locus(mk_locus(SYM_A, SYM_C, SYM_G, SYM_T, SYM_A, SYM_G, 1'b0));
        send_locus(mk_locus(SYM_MISSING, SYM_MISSING, SYM_A, SYM_G, SYM_A, SYM_G, 1'b0));
        send_locus(mk_locus(SYM_A, SYM_MISSING, SYM_MISSING, SYM_T, SYM_C, SYM_T, 1'b0));
        send_locus(mk_locus(SYM_A, SYM_A, SYM_G, SYM_G, SYM_A, SYM_G, 1'b0));
        send_locus(mk_locus(SYM_A, SYM_C, SYM_G, SYM_G, SYM_A, SYM_G, 1'b0));
        // impossible locus
        send_locus(mk_locus(SYM_C, SYM_C, SYM_C, SYM_C, SYM_A, SYM_G, 1'b0));
        send_locus(mk_locus(SYM_G, SYM_G, SYM_G, SYM_G, SYM_A, SYM_G, 1'b1));

        // zero window: no locus examined, impossible flag stays clear
        change_setting(4'd3, 5'd0, 1'b1);
        send_locus(mk_locus(SYM_C, SYM_C, SYM_C, SYM_C, SYM_A, SYM_G, 1'b0));
        send_locus(mk_locus(SYM_A, SYM_C, SYM_G, SYM_T, SYM_A, SYM_G, 1'b1));

        // oversized window behaves as the deepest one
        change_setting(4'd2, 5'd31, 1'b0);
        send_locus(mk_locus(SYM_A, SYM_C, SYM_G, SYM_T, SYM_A, SYM_G, 1'b0));
        send_locus(mk_locus(SYM_T, SYM_T, SYM_T, SYM_T, SYM_A, SYM_T, 1'b0));
        send_locus(mk_locus(SYM_A, SYM_A, SYM_C, SYM_C, SYM_A, SYM_C, 1'b0));
        send_locus(mk_locus(SYM_MISSING, SYM_G, SYM_A, SYM_MISSING, SYM_A, SYM_G, 1'b1));

        // largest degree, then degree zero
        change_setting(4'd15, 5'd16, 1'b1);
        send_locus(mk_locus(SYM_A, SYM_C, SYM_A, SYM_C, SYM_A, SYM_C, 1'b0));
        send_locus(mk_locus(SYM_A, SYM_A, SYM_A, SYM_A, SYM_A, SYM_C, 1'b0));
        send_locus(mk_locus(SYM_G, SYM_T, SYM_C, SYM_A, SYM_A, SYM_C, 1'b1));
        change_setting(4'd0, 5'd16, 1'b0);
        send_locus(mk_locus(SYM_A, SYM_C, SYM_A, SYM_C, SYM_A, SYM_C, 1'b0));
        send_locus(mk_locus(SYM_A, SYM_A, SYM_G, SYM_G, SYM_A, SYM_C, 1'b1));
        send_locus(mk_locus(8'h5A, 8'hA5, 8'h33, 8'hCC, 8'h0F, 8'hF0, 1'b1));

        // random phases, each under one register setting
        random_loci = 0;
        phase = 0;
        while (random_loci < RANDOM_LOCI)
        begin
            if (phase < 8)
                change_setting(FIX_DEG[phase], FIX_WIN[phase], FIX_ADD[phase]);
            else if ($urandom_range(0, 3) == 0)
                change_setting(4'($urandom_range(9, 15)), 5'($urandom_range(0, 31)),
                               1'($urandom_range(0, 1)));
            else
                change_setting(4'($urandom_range(0, 8)), 5'($urandom_range(0, 16)),
                               1'($urandom_range(0, 1)));
            no_idle = ($urandom_range(0, 3) == 0);
            n_strings = $urandom_range(3, 8);
            for (int unsigned s = 0; s < n_strings; s++)
            begin
                r = $urandom_range(0, 99);
                if (s == 0 && sb.degree == 4'd15)
                    mode = CONTENT_DENSE;    // long all-scoring string drives saturation
                else if (r < 60)
                    mode = CONTENT_MIXED;
                else if (r < 85)
                    mode = CONTENT_DENSE;
                else
                    mode = CONTENT_NOISE;
                if (mode == CONTENT_DENSE)
                    len = $urandom_range(20, 40);
                else if ($urandom_range(0, 3) != 0)
                    len = $urandom_range(1, 12);
                else
                    len = $urandom_range(13, 28);
                send_string(mode, len);
                random_loci += len;
            end
            phase++;
        end

        // drain and let the block settle
        s_axis_tvalid <= 1'b0;
        no_idle = 1'b0;
        while (sb.totals_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.totals_due.size() != 0)
            sb.report_mismatch("totals never emitted", 64'(sb.totals_due.size()), 64'd0);

        $display("Sent %0d loci under %0d register settings; %0d kernel totals compared.",
                 loci_sent, settings_used, sb.totals_checked);
        $display("Totals with saturation: %0d, with impossible loci: %0d, mismatches: %0d.",
                 sb.saturated_count, sb.impossible_count, sb.mismatches);
        if (sb.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: sim.f
design/gwpk_pkg.sv
design/gwpk_ctrl.sv
design/gwpk_datapath.sv
design/genotype_window_poly_kernel.sv
design/gwpk_checker.sv
tb/sv/tb_genotype_window_poly_kernel.sv
